// ===== rtl/smabd_pkg.sv =====
// Shared types and constants for the sensor moving-average bar display unit.
// No dependencies; imported by every module of the block.

package smabd_pkg;

	// Averaging window length
	localparam int WINDOW = 10;

	// Raw sample and scaled distance
	localparam int RAW_W      = 16;
	localparam int RAW_MAX    = 1023;
	localparam int RAW_OK_W   = $clog2(RAW_MAX + 1);
	localparam int DIST_SCALE = 30;
	localparam int DIST_W     = 5;

	// distance = (raw * SCALE_MUL) >> SCALE_SHIFT, exact for every raw up to RAW_MAX
	localparam int SCALE_SHIFT = 20;
	localparam int SCALE_MUL   = (DIST_SCALE * (2 ** SCALE_SHIFT) + RAW_MAX - 1) / RAW_MAX;
	localparam int SCALE_MUL_W = $clog2(SCALE_MUL + 1);
	localparam int SCALE_PROD_W = RAW_OK_W + SCALE_MUL_W;

	// Running sum and average: average = (sum * AVG_MUL) >> AVG_SHIFT, exact below 2**SUM_W
	localparam int SUM_W      = 9;
	localparam int AVG_SHIFT  = 18;
	localparam int AVG_MUL    = ((2 ** AVG_SHIFT) + WINDOW - 1) / WINDOW;
	localparam int AVG_MUL_W  = $clog2(AVG_MUL + 1);
	localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;

	// Accepted sample count, saturating at WINDOW + 1
	localparam int CNT_W = $clog2(WINDOW + 2);

	// Levels and LED bar
	localparam int LVL_W  = 5;
	localparam int LED_W  = 4;
	localparam logic [LED_W-1:0] LED_OFF   = 4'b0000;
	localparam logic [LED_W-1:0] LED_ONE   = 4'b0001;
	localparam logic [LED_W-1:0] LED_TWO   = 4'b0011;
	localparam logic [LED_W-1:0] LED_THREE = 4'b0111;
	localparam logic [LED_W-1:0] LED_FOUR  = 4'b1111;

	localparam logic [LVL_W-1:0] LEVEL_HIGH_RST = 5'd30;
	localparam logic [LVL_W-1:0] LEVEL_MID_RST  = 5'd20;
	localparam logic [LVL_W-1:0] LEVEL_LOW_RST  = 5'd10;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEVEL_HIGH = 2'd0,
		CFG_LEVEL_MID  = 2'd1,
		CFG_LEVEL_LOW  = 2'd2
	} cfg_idx_t;

	// Stream widths
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	// Display thresholds
	typedef struct packed {
		logic [LVL_W-1:0] high;
		logic [LVL_W-1:0] mid;
		logic [LVL_W-1:0] low;
	} levels_t;

	// One result item
	typedef struct packed {
		logic [LED_W-1:0]  bar_leds;
		logic              display_valid;
		logic [DIST_W-1:0] average;
		logic              rejected;
	} result_t;

endpackage

// ===== rtl/smabd_cell.sv =====
// One cell of the distance shift line: holds a single scaled distance.
// Depends on smabd_pkg.

module smabd_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic [smabd_pkg::DIST_W-1:0] d,
	output logic [smabd_pkg::DIST_W-1:0] q
);
	import smabd_pkg::*;

	logic [DIST_W-1:0] dist_q;

	// Take the neighbour's distance on every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (shift) begin
			dist_q <= d;
		end
	end

	assign q = dist_q;

endmodule

// ===== rtl/smabd_scale.sv =====
// Input stage: range check and scaling of the raw sample to a distance.
// Depends on smabd_pkg.

module smabd_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [smabd_pkg::RAW_W-1:0]   raw_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          rejected,
	output logic [smabd_pkg::DIST_W-1:0]  distance
);
	import smabd_pkg::*;

	logic                    v_s1;
	logic                    rej_s1;
	logic [DIST_W-1:0]       dist_s1;
	logic                    raw_ok;
	logic [SCALE_PROD_W-1:0] prod;

	// Range check and reciprocal multiply for raw * 30 / 1023
	assign raw_ok = (raw_sample <= RAW_W'(RAW_MAX));
	assign prod   = SCALE_PROD_W'(raw_sample[RAW_OK_W-1:0]) *
	                SCALE_PROD_W'(SCALE_MUL);

	assign in_ready = !v_s1 || out_ready;

	// Hold valid until the state stage takes the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rej_s1  <= !raw_ok;
			dist_s1 <= prod[SCALE_SHIFT +: DIST_W];
		end
	end

	assign out_valid = v_s1;
	assign rejected  = rej_s1;
	assign distance  = dist_s1;

endmodule

// ===== rtl/smabd_disp.sv =====
// Output stage: average from the running sum, LED bar decode and output register.
// Depends on smabd_pkg.

module smabd_disp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          rejected,
	input  logic [smabd_pkg::SUM_W-1:0]   running_sum,
	input  logic                          display_valid,
	input  smabd_pkg::levels_t            levels,
	output logic                          out_valid,
	input  logic                          out_ready,
	output smabd_pkg::result_t            result
);
	import smabd_pkg::*;

	logic                  vo_q;
	result_t               res_q;
	logic [AVG_PROD_W-1:0] prod;
	logic [DIST_W-1:0]     avg;
	logic [LED_W-1:0]      leds;

	// Divide by the window through a reciprocal multiply
	assign prod = AVG_PROD_W'(running_sum) * AVG_PROD_W'(AVG_MUL);
	assign avg  = prod[AVG_SHIFT +: DIST_W];

	// Pick the bar pattern in priority order high, mid, low
	always_comb begin
		if (!display_valid) begin
			leds = LED_OFF;
		end else if (avg >= levels.high) begin
			leds = LED_ONE;
		end else if (avg >= levels.mid) begin
			leds = LED_TWO;
		end else if (avg >= levels.low) begin
			leds = LED_THREE;
		end else begin
			leds = LED_FOUR;
		end
	end

	assign in_ready = !vo_q || out_ready;

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (in_ready) begin
			vo_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q.rejected      <= rejected;
			res_q.average       <= avg;
			res_q.display_valid <= display_valid;
			res_q.bar_leds      <= leds;
		end
	end

	assign out_valid = vo_q;
	assign result    = res_q;

endmodule

// ===== rtl/sensor_moving_average_bar_display_unit.sv =====
// Top level of the sensor moving-average bar display unit.
// Depends on smabd_pkg, smabd_scale, smabd_cell and smabd_disp.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | s_tvalid / s_tready    | s_tdata: raw_sample [15:0]
//  output   | m_tvalid / m_tready    | m_tdata: rejected [0], average [5:1],
//           |                        |   display_valid [6], bar_leds [10:7]
//  config   | cfg_we (no back-press) | cfg_index, cfg_wdata: 0 high, 1 mid, 2 low
//
// One sample per cycle while m_tready is high; a result is offered once its
// sample has passed one register each for the scale multiply, the shift-line
// and running-sum update, and the average multiply with bar decode.
// Reset clears shift line, running sum and count, presets levels; all at once.
// Each stage holds while the one after it is full and stalled, so a waiting result
// blocks the input only once all three stages are occupied.

module sensor_moving_average_bar_display_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// raw_sample [15:0]
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [smabd_pkg::IN_DATA_W-1:0]     s_tdata,
	// rejected [0], average [5:1], display_valid [6], bar_leds [10:7], zero [15:11]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [smabd_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                                cfg_we,
	input  logic [smabd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smabd_pkg::LVL_W-1:0]         cfg_wdata
);
	import smabd_pkg::*;

	logic              v1;
	logic              rej1;
	logic [DIST_W-1:0] dist1;
	logic              rdy2;
	logic              v_s2_q;
	logic              rej_s2_q;
	logic              rdy_o;
	logic              take2;
	logic              shift;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	levels_t           levels_q;
	result_t           result;
	logic [DIST_W-1:0] line_d [WINDOW];
	logic [DIST_W-1:0] line_q [WINDOW];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q.high <= LEVEL_HIGH_RST;
			levels_q.mid  <= LEVEL_MID_RST;
			levels_q.low  <= LEVEL_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEVEL_HIGH: levels_q.high <= cfg_wdata;
				CFG_LEVEL_MID:  levels_q.mid  <= cfg_wdata;
				CFG_LEVEL_LOW:  levels_q.low  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Range check and scaling
	smabd_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.raw_sample (s_tdata[RAW_W-1:0]),
		.out_valid  (v1),
		.out_ready  (rdy2),
		.rejected   (rej1),
		.distance   (dist1)
	);

	assign rdy2  = !v_s2_q || rdy_o;
	assign take2 = v1 && rdy2;
	assign shift = take2 && !rej1;

	// Shift line of distances: newest enters cell 0, oldest leaves the last cell
	genvar gi;
	generate
		for (gi = 0; gi < WINDOW; gi++) begin : g_line
			if (gi == 0) begin : g_head
				assign line_d[gi] = dist1;
			end else begin : g_body
				assign line_d[gi] = line_q[gi-1];
			end
			smabd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (line_d[gi]),
				.q      (line_q[gi])
			);
		end
	endgenerate

	// Running sum and saturating count of accepted samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (shift) begin
			sum_q <= sum_q + SUM_W'(dist1) - SUM_W'(line_q[WINDOW-1]);
			if (count_q <= CNT_W'(WINDOW)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// State stage valid and rejected flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q <= 1'b0;
		end else if (rdy2) begin
			v_s2_q <= v1;
		end
	end

	always_ff @(posedge clk) begin
		if (take2) begin
			rej_s2_q <= rej1;
		end
	end

	// Average, bar decode and output register
	smabd_disp u_disp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v_s2_q),
		.in_ready      (rdy_o),
		.rejected      (rej_s2_q),
		.running_sum   (sum_q),
		.display_valid (count_q > CNT_W'(WINDOW)),
		.levels        (levels_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.result        (result)
	);

	assign m_tdata = OUT_DATA_W'(result);

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sensor moving-average bar display unit.
// Checks each result against a local model of the distance filter and LED bar.
// Depends on smabd_pkg and sensor_moving_average_bar_display_unit.

module tb_top;
	import smabd_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 150;
	localparam int DIST_MAX     = 30;
	// unused register slot: writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// raw_sample [15:0]
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// rejected [0], average [5:1], display_valid [6], bar_leds [10:7], zero [15:11]
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [LVL_W-1:0]      cfg_wdata = '0;

	// filter model state
	logic [DIST_W-1:0] dist_ring [WINDOW];
	logic [SUM_W-1:0]  dist_sum;
	int                ring_pos;
	int                accepted;
	levels_t           levels;

	result_t expected_results [$];
	int      errors        = 0;
	int      cycles        = 0;
	int      src_idle_pct  = 0;
	int      sink_idle_pct = 0;
	int      hold_request  = 0;
	int      hold_left     = 0;

	always #CLK_HALF clk = ~clk;

	sensor_moving_average_bar_display_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Advance the model by one reading and return the result it gives
	function automatic result_t advance_filter(logic [RAW_W-1:0] raw);
		result_t           r;
		logic [DIST_W-1:0] dist_val;
		logic [DIST_W-1:0] avg;
		r = '0;
		if (raw > RAW_MAX) begin
			r.rejected = 1'b1;
		end else begin
			dist_val = DIST_W'((int'(raw) * DIST_SCALE) / RAW_MAX);
			dist_sum = dist_sum - dist_ring[ring_pos] + dist_val;
			dist_ring[ring_pos] = dist_val;
			ring_pos = (ring_pos + 1) % WINDOW;
			if (accepted <= WINDOW)
				accepted++;
		end
		avg = DIST_W'(dist_sum / WINDOW);
		r.average = avg;
		r.display_valid = (accepted > WINDOW);
		// thresholds tested in priority order, whatever their values
		if (!r.display_valid)
			r.bar_leds = LED_OFF;
		else if (avg >= levels.high)
			r.bar_leds = LED_ONE;
		else if (avg >= levels.mid)
			r.bar_leds = LED_TWO;
		else if (avg >= levels.low)
			r.bar_leds = LED_THREE;
		else
			r.bar_leds = LED_FOUR;
		return r;
	endfunction

	function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	// Offer one reading; return at the edge where the request is taken
	task automatic send_sample(logic [RAW_W-1:0] raw);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		do
			@(negedge clk);
		while (!s_tready);
		@(posedge clk);
		expected_results.push_back(advance_filter(raw));
	endtask

	// Stop offering and wait until every result is back and the pipe is empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_level(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_LEVEL_HIGH: levels.high = val;
			CFG_LEVEL_MID:  levels.mid  = val;
			CFG_LEVEL_LOW:  levels.low  = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_levels(levels_t lv);
		write_level(CFG_LEVEL_HIGH, lv.high);
		write_level(CFG_LEVEL_MID, lv.mid);
		write_level(CFG_LEVEL_LOW, lv.low);
	endtask

	// Feed a plateau of readings that all scale to one distance
	task automatic hold_distance(int target_dist, int count);
		int raw;
		if (target_dist < 0)
			target_dist = 0;
		if (target_dist > DIST_MAX)
			target_dist = DIST_MAX;
		raw = (target_dist * RAW_MAX + DIST_SCALE - 1) / DIST_SCALE;
		repeat (count) send_sample(RAW_W'(raw));
	endtask

	// Mostly readings near a target, with extremes and out-of-range noise
	function automatic logic [RAW_W-1:0] random_reading(int target);
		int raw;
		case ($urandom_range(15))
			0: return RAW_W'($urandom_range(16'hFFFF));
			1: return RAW_W'(RAW_MAX);
			2: return '0;
			3: return RAW_W'(RAW_MAX + 1 + $urandom_range(64));
			default: begin
				raw = target + int'($urandom_range(80)) - 40;
				if (raw < 0)
					raw = 0;
				if (raw > RAW_MAX)
					raw = RAW_MAX;
				return RAW_W'(raw);
			end
		endcase
	endfunction

	// Boundaries of the scaling, rejection before and after the display is valid
	task automatic test_directed_edges();
		logic [RAW_W-1:0] readings [17] = '{
			16'd1024, 16'hFFFF, 16'd0, 16'd1023, 16'd34, 16'd35, 16'd1022,
			16'h8000, 16'd512, 16'h03FF, 16'h7FFF, 16'd1023, 16'd1023,
			16'd1023, 16'd1023, 16'hFFFF, 16'h5555
		};
		src_idle_pct  = 6;
		sink_idle_pct = 60;
		foreach (readings[i])
			send_sample(readings[i]);
		wait_drained();
	endtask

	// Plateaus around each threshold under several level settings
	task automatic test_levels();
		levels_t settings [5];
		settings[0] = '{high: LEVEL_HIGH_RST, mid: LEVEL_MID_RST, low: LEVEL_LOW_RST};
		settings[1] = '{high: 5'd0, mid: 5'd0, low: 5'd0};
		settings[2] = '{high: 5'd31, mid: 5'd31, low: 5'd31};
		settings[3] = '{high: 5'd5, mid: 5'd25, low: 5'd15};
		settings[4] = '{high: 5'd12, mid: 5'd12, low: 5'd12};
		src_idle_pct  = 6;
		sink_idle_pct = 60;
		foreach (settings[i]) begin
			set_levels(settings[i]);
			// the spare slot must leave all levels alone
			if (i == 2)
				write_level(CFG_SPARE, 5'd7);
			hold_distance(0, WINDOW);
			hold_distance(int'(levels.low) - 1, WINDOW);
			hold_distance(int'(levels.low), WINDOW);
			hold_distance(int'(levels.mid), WINDOW);
			hold_distance(int'(levels.high) - 1, WINDOW);
			hold_distance(int'(levels.high), WINDOW);
			hold_distance(DIST_MAX, WINDOW);
			wait_drained();
		end
	endtask

	// Runs of readings around random targets under random levels
	task automatic test_random_stream(int items, int src_pct, int sink_pct);
		levels_t lv;
		int      target;
		int      sent;
		lv = '{high: LVL_W'($urandom), mid: LVL_W'($urandom), low: LVL_W'($urandom)};
		set_levels(lv);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		sent = 0;
		while (sent < items) begin
			target = $urandom_range(RAW_MAX);
			repeat ($urandom_range(4, 24)) begin
				send_sample(random_reading(target));
				sent++;
			end
		end
		wait_drained();
	endtask

	// Hold the output off while requests keep coming, so the input stalls
	task automatic test_stalled_output();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_request  = HOLD_CYCLES;
		repeat (40) send_sample(random_reading($urandom_range(RAW_MAX)));
		wait_drained();
	endtask

	// Output ready: random idling, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Compare each result taken at the coming edge with the oldest expectation
	always @(negedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[$bits(result_t)-1:0]);
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected, expected none actual %h", $time, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("rejected", 8'(want.rejected), 8'(got.rejected));
				check_field("average", 8'(want.average), 8'(got.average));
				check_field("display_valid", 8'(want.display_valid),
					8'(got.display_valid));
				check_field("bar_leds", 8'(want.bar_leds), 8'(got.bar_leds));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		levels   = '{high: LEVEL_HIGH_RST, mid: LEVEL_MID_RST, low: LEVEL_LOW_RST};
		dist_sum = '0;
		ring_pos = 0;
		accepted = 0;
		foreach (dist_ring[i])
			dist_ring[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_levels();
		test_random_stream(90, 6, 60);
		test_random_stream(90, 60, 6);
		test_random_stream(100, 0, 0);
		test_stalled_output();
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/smabd_pkg.sv
rtl/smabd_cell.sv
rtl/smabd_scale.sv
rtl/smabd_disp.sv
rtl/sensor_moving_average_bar_display_unit.sv
dv/tb_top.sv
